// ===== rtl/pressure_power_limiter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pressure power limiter
// Same-cycle and next-cycle implication checks on clk_i, idle in reset.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_POWER_LIMITER_ASSERT_SVH
`define PRESSURE_POWER_LIMITER_ASSERT_SVH

// Check cons in the cycle where ante holds.
`define PPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante holds.
`define PPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pplim_pkg.sv =====
// ----------------------------------------------------------------------------
// pplim_pkg
// Types and fixed constants shared by the pressure power limiter files.
// ----------------------------------------------------------------------------
package pplim_pkg;

  // Timing intervals in milliseconds
  localparam logic [31:0] FLOOD_HOLDOFF_MS  = 32'd5000;
  localparam logic [31:0] FLOOD_PAUSE_MS    = 32'd30000;
  localparam logic [31:0] DECAY_INTERVAL_MS = 32'd60000;

  // Power limits in percent
  localparam logic [6:0] FULL_POWER      = 7'd100;
  localparam logic [6:0] FLOOD_FLOOR     = 7'd30;
  localparam logic [6:0] FLOOD_POWER_MAX = 7'd85;
  localparam logic [7:0] OVERRIDE_MAX    = 8'd100;

  // Reduction bookkeeping
  localparam logic [6:0] FLOOD_STEP     = 7'd15;
  localparam logic [6:0] FREQUENT_STEP  = 7'd10;
  localparam logic [7:0] FREQUENT_AFTER = 8'd3;
  localparam logic [6:0] REDUCTION_CAP  = 7'd50;
  localparam logic [5:0] DECAY_STEP     = 6'd5;

  // floor(h * 85 / 100) == (h * FLOOD_MUL) >> FLOOD_SHIFT for h in 0..100
  localparam int          FLOOD_SHIFT = 19;
  localparam logic [18:0] FLOOD_MUL   = 19'd445655;

  // Serial divider: dividend is pressure * 100 (< 2^22), divisor 15 bits
  localparam int DVD_W = 22;
  localparam int DSR_W = 15;
  localparam int QUO_W = 7;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DVD_W);

  // Pressure status codes
  localparam logic [1:0] STATUS_NORMAL = 2'd0;
  localparam logic [1:0] STATUS_WARN   = 2'd1;
  localparam logic [1:0] STATUS_CRIT   = 2'd2;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_OVERRIDE = 2'd0,
    REG_WORK     = 2'd1,
    REG_WARN     = 2'd2,
    REG_CRIT     = 2'd3
  } pplim_reg_e;

  typedef struct packed {
    logic start;
  } pplim_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pplim_div_stat_t;

endpackage

// ===== rtl/pplim_div.sv =====
// ----------------------------------------------------------------------------
// pplim_div
// Bit-serial restoring divider, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pplim_div
  import pplim_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pplim_div_req_t   req_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output pplim_div_stat_t  stat_o,
  output logic [QUO_W-1:0] quotient_o
);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             take;

  // Shift next dividend bit into the partial remainder, subtract on fit
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign take  = trial >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d = dividend_i;
      dsr_d = divisor_i;
      rem_d = '0;
      quo_d = '0;
      cnt_d = DIV_STEPS;
    end else if (cnt_q != '0) begin
      dvd_d  = {dvd_q[DVD_W-2:0], 1'b0};
      rem_d  = take ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo_d  = {quo_q[QUO_W-2:0], take};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ===== rtl/pressure_power_limiter.sv =====
// ----------------------------------------------------------------------------
// pressure_power_limiter: an item goes through EVAL, then DIV when the linear
// power needs the bit-serial divider (22 steps, one per dividend bit of
// pressure * 100), then FIN, which waits until the output register is free.
// A new input transaction is taken only once the result enters the output
// register. Reset clears the limiter state, the sequencer, the output valid
// and the configuration registers; override resets to off (-1).
// ----------------------------------------------------------------------------
module pressure_power_limiter
  import pplim_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] pressure_sample_i,
  input  logic [31:0]        now_ms_i,
  input  logic [6:0]         heater_level_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [6:0]         power_out_o,
  output logic               flood_detected_o,
  output logic [6:0]         flood_power_o,
  output logic               in_pause_o,
  output logic [1:0]         pressure_status_o
);

  // Sequencer: take an item, evaluate it, optionally divide, then hand off
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } pplim_state_e;

  pplim_state_e state_q, state_d;

  // Configuration registers
  logic [7:0]  override_q;
  logic [14:0] work_q, warn_q, crit_q;
  logic        cfg_wr;
  pplim_reg_e  cfg_idx;

  // Limiter state
  logic [31:0] last_q, last_d;
  logic [31:0] pause_q, pause_d;
  logic [7:0]  count_q, count_d;
  logic [5:0]  red_q, red_d;

  // Captured input item
  logic signed [15:0] p_q;
  logic [31:0]        now_q;
  logic [6:0]         heat_q;

  // Per-item results waiting for the final step
  logic [6:0] rec_q, rec_d;
  logic [5:0] sub_q, sub_d;
  logic       flood_q, flood_d;
  logic [6:0] fpow_q, fpow_d;
  logic       paused_q, paused_d;
  logic [1:0] status_q, status_d;

  // Output register
  logic       out_valid_q;
  logic [6:0] o_power_q;
  logic       o_flood_q;
  logic [6:0] o_fpow_q;
  logic       o_pause_q;
  logic [1:0] o_status_q;

  // Divider hookup
  pplim_div_req_t   div_req;
  pplim_div_stat_t  div_stat;
  logic [DVD_W-1:0] div_dividend;
  logic [QUO_W-1:0] div_quo;

  // Evaluation signals
  logic signed [16:0] p_ext;
  logic        ge_crit, ge_warn;
  logic        ov_on;
  logic [31:0] since_flood, since_last;
  logic        flood;
  logic [7:0]  count_n;
  logic [6:0]  red_a, red_ac, red_b, red_bc;
  logic [5:0]  red1, red2;
  logic [31:0] last1, pause1;
  logic        paused;
  logic [25:0] fprod;
  logic [6:0]  fpow_raw, fpow;
  logic        decay;
  logic        p_pos, p_full, need_div;
  logic [14:0] pmag;
  logic [6:0]  pw_diff, pw_final;
  logic        load_out;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, write on the access phase
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = pplim_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      override_q <= 8'hFF;
      work_q     <= '0;
      warn_q     <= '0;
      crit_q     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OVERRIDE: override_q <= pwdata[7:0];
        REG_WORK:     work_q     <= pwdata[14:0];
        REG_WARN:     warn_q     <= pwdata[14:0];
        REG_CRIT:     crit_q     <= pwdata[14:0];
      endcase
    end
  end

  // Read back; override is signed, so sign-extend it
  always_comb begin
    unique case (cfg_idx)
      REG_OVERRIDE: prdata = {{24{override_q[7]}}, override_q};
      REG_WORK:     prdata = {17'b0, work_q};
      REG_WARN:     prdata = {17'b0, warn_q};
      REG_CRIT:     prdata = {17'b0, crit_q};
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input capture; saturate heater level to full power on the way in
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      p_q    <= pressure_sample_i;
      now_q  <= now_ms_i;
      heat_q <= (heater_level_i > FULL_POWER) ? FULL_POWER : heater_level_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Evaluation: status, flood decision, pause, decay
  // ---------------------------------------------------------------------------
  // Thresholds are non-negative; compare against a signed sample
  assign p_ext   = {p_q[15], p_q};
  assign ge_crit = p_ext >= $signed({2'b00, crit_q});
  assign ge_warn = p_ext >= $signed({2'b00, warn_q});

  // Only 0..100 forces the power; negative and 101..127 leave it off
  assign ov_on = (override_q <= OVERRIDE_MAX);

  // Holdoff uses a wrapping difference
  assign since_flood = now_q - last_q;
  assign flood       = !ov_on && ge_crit && (since_flood >= FLOOD_HOLDOFF_MS);
  assign count_n     = flood ? count_q + 8'd1 : count_q;

  // Add the flood step, then the frequent-flood step once the count passes FREQUENT_AFTER, capping each time
  assign red_a  = {1'b0, red_q} + FLOOD_STEP;
  assign red_ac = (red_a > REDUCTION_CAP) ? REDUCTION_CAP : red_a;
  assign red_b  = red_ac + FREQUENT_STEP;
  assign red_bc = (red_b > REDUCTION_CAP) ? REDUCTION_CAP : red_b;
  assign red1   = !flood ? red_q
                : (count_n > FREQUENT_AFTER) ? red_bc[5:0] : red_ac[5:0];

  assign last1  = flood ? now_q : last_q;
  assign pause1 = flood ? now_q + FLOOD_PAUSE_MS : pause_q;

  // Pause test is a plain unsigned compare, no wrap handling
  assign paused = !ov_on && (now_q < pause1);

  // Flood power: floor(85 %) by reciprocal multiply, held at the floor
  assign fprod    = 26'(heat_q) * 26'(FLOOD_MUL);
  assign fpow_raw = fprod[FLOOD_SHIFT +: 7];
  assign fpow     = (fpow_raw < FLOOD_FLOOR) ? FLOOD_FLOOR : fpow_raw;

  // Decay only outside a pause, measured from the updated flood time
  assign since_last = now_q - last1;
  assign decay      = !ov_on && !paused && (red1 != '0) &&
                      (since_last > DECAY_INTERVAL_MS);
  assign red2       = (red1 >= DECAY_STEP) ? red1 - DECAY_STEP : '0;

  // Linear power: clamp ends directly, divide only strictly inside the range
  assign pmag         = p_q[14:0];
  assign p_pos        = !p_q[15] && (pmag != '0);
  assign p_full       = p_pos && (pmag >= work_q);
  assign need_div     = !ov_on && !paused && p_pos && !p_full;
  assign div_dividend = (DVD_W'(pmag) << 6) + (DVD_W'(pmag) << 5) + (DVD_W'(pmag) << 2);
  assign div_req.start = (state_q == ST_EVAL) && need_div;

  pplim_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (work_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and state update
  // ---------------------------------------------------------------------------
  assign pw_diff  = rec_q - {1'b0, sub_q};
  assign pw_final = (rec_q > {1'b0, sub_q}) ? pw_diff : '0;
  assign load_out = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    last_d   = last_q;
    pause_d  = pause_q;
    count_d  = count_q;
    red_d    = red_q;
    rec_d    = rec_q;
    sub_d    = sub_q;
    flood_d  = flood_q;
    fpow_d   = fpow_q;
    paused_d = paused_q;
    status_d = status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        status_d = ge_crit ? STATUS_CRIT : ge_warn ? STATUS_WARN : STATUS_NORMAL;
        flood_d  = flood;
        fpow_d   = flood ? fpow : '0;
        paused_d = paused;
        // Commit state only when the override is off
        if (!ov_on) begin
          count_d = count_n;
          pause_d = pause1;
          red_d   = decay ? red2 : red1;
          last_d  = decay ? now_q : last1;
        end
        // Forced and paused results bypass the reduction
        sub_d   = '0;
        state_d = ST_FIN;
        priority if (ov_on) begin
          rec_d = override_q[6:0];
        end else if (paused) begin
          rec_d = flood ? fpow : heat_q;
        end else begin
          // Linear path subtracts the reduction before decay
          sub_d = red1;
          if (need_div) begin
            state_d = ST_DIV;
          end else begin
            rec_d = p_full ? FULL_POWER : '0;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          rec_d   = div_quo;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= '0;
      pause_q <= '0;
      count_q <= '0;
      red_q   <= '0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      pause_q <= pause_d;
      count_q <= count_d;
      red_q   <= red_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q    <= rec_d;
    sub_q    <= sub_d;
    flood_q  <= flood_d;
    fpow_q   <= fpow_d;
    paused_q <= paused_d;
    status_q <= status_d;
  end

  // ---------------------------------------------------------------------------
  // Output register: hold until the transaction completes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_power_q  <= pw_final;
      o_flood_q  <= flood_q;
      o_fpow_q   <= fpow_q;
      o_pause_q  <= paused_q;
      o_status_q <= status_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign power_out_o       = o_power_q;
  assign flood_detected_o  = o_flood_q;
  assign flood_power_o     = o_fpow_q;
  assign in_pause_o        = o_pause_q;
  assign pressure_status_o = o_status_q;

endmodule

// ===== rtl/pplim_checker.sv =====
// ----------------------------------------------------------------------------
// pplim_checker
// Port-level checks on the result channel of the pressure power limiter.
// ----------------------------------------------------------------------------
`include "pressure_power_limiter_assert.svh"

module pplim_checker
  import pplim_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] power_out_o,
  input logic       flood_detected_o,
  input logic [6:0] flood_power_o,
  input logic [1:0] pressure_status_o
);

  `PPL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  `PPL_ASSERT_NOW(a_power_range, out_valid_o, power_out_o <= FULL_POWER && (pressure_status_o == STATUS_NORMAL || pressure_status_o == STATUS_WARN || pressure_status_o == STATUS_CRIT), "power or status out of range")

  `PPL_ASSERT_NOW(a_flood_power, out_valid_o && flood_detected_o, flood_power_o >= FLOOD_FLOOR && flood_power_o <= FLOOD_POWER_MAX, "flood power out of range")

  `PPL_ASSERT_NOW(a_no_flood_power, out_valid_o && !flood_detected_o, flood_power_o == '0, "flood power without flood")

  `PPL_ASSERT_NOW(a_flood_is_crit, out_valid_o && flood_detected_o, pressure_status_o == STATUS_CRIT, "flood without critical status")

endmodule

bind pressure_power_limiter pplim_checker u_pplim_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .power_out_o       (power_out_o),
  .flood_detected_o  (flood_detected_o),
  .flood_power_o     (flood_power_o),
  .pressure_status_o (pressure_status_o)
);
